// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the lookup RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define SACF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define SACF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/sacf_pkg.sv =====
// Package for the set-associative FIFO-replacement lookup unit.
// Field widths, register reset values, register indexes. No dependencies.
`default_nettype none

package sacf_pkg;

  // Transaction field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SET_W     = 6;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned WAY_OUT_W = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned OFFSET_W   = 5;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned WAYS_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_e;

  // Register reset values and limits
  localparam logic [OFFSET_W-1:0] OFFSET_RST   = 5'd3;
  localparam logic [INDEX_W-1:0]  INDEX_RST    = 3'd4;
  localparam logic [WAYS_W-1:0]   WAYS_RST     = 4'd1;
  localparam logic [INDEX_W-1:0]  INDEX_MAX    = 3'd6;

  // Parameter defaults
  localparam int unsigned MAX_SETS_DEF  = 64;
  localparam int unsigned MAX_WAYS_DEF  = 8;
  localparam int unsigned ADDR_BITS_DEF = 32;

endpackage

`default_nettype wire

// ===== rtl/core/sacf_if.sv =====
// Valid/ready channel interfaces for the lookup unit: address in, result out.
// Depends on sacf_pkg for the field widths.
`default_nettype none

interface sacf_req_if;
  logic                       valid;
  logic                       ready;
  logic [sacf_pkg::ADDR_W-1:0] byte_address;

  modport source (output valid, output byte_address, input ready);
  modport sink   (input valid, input byte_address, output ready);
endinterface

interface sacf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [sacf_pkg::SET_W-1:0]     set_number;
  logic [sacf_pkg::TAG_W-1:0]     line_tag;
  logic [sacf_pkg::WAY_OUT_W-1:0] way_used;

  modport source (output valid, output hit, output set_number, output line_tag,
                  output way_used, input ready);
  modport sink   (input valid, input hit, input set_number, input line_tag,
                  input way_used, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/set_assoc_cache_fifo_lookup_unit.sv =====
// Set-associative cache tag lookup with FIFO replacement, top level.
// Depends on sacf_pkg, sacf_if.sv and assert_macros.svh.
//
//   channel | dir | handshake      | payload
//   --------+-----+----------------+-----------------------------------------
//   req     | in  | valid / ready  | byte_address
//   rsp     | out | valid / ready  | hit, set_number, line_tag, way_used
//   cfg     | in  | cfg_we_i       | cfg_idx_i, cfg_wdata_i (no read-back)
//
// One transaction per cycle unless the result stalls; set row read at accept,
// way compare, write-back and result register load as the lookup stage fires.
// A row written back at the edge it is read again is forwarded.
// Reset clears per-row valid flags only: no clearing pass, ready right away.
// A stalled result holds the pipe; req.ready drops only when the lookup stage
// and the result register are both full and the result is not taken.
`default_nettype none
`include "assert_macros.svh"

module set_assoc_cache_fifo_lookup_unit #(
  parameter int unsigned MAX_SETS  = sacf_pkg::MAX_SETS_DEF,
  parameter int unsigned MAX_WAYS  = sacf_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_BITS = sacf_pkg::ADDR_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  sacf_req_if.sink                           req,
  sacf_rsp_if.source                         rsp,
  input  wire logic                          cfg_we_i,
  input  wire logic [sacf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sacf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sacf_pkg::*;

  localparam int unsigned ROW_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned NSETS = 1 << SET_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? '1 : ((ADDR_W'(1) << ADDR_BITS) - ADDR_W'(1));

  typedef struct packed {
    logic [MAX_WAYS-1:0][TAG_W-1:0] tags;
    logic [MAX_WAYS-1:0]            vld;
    logic [WAY_W-1:0]               ptr;
  } row_t;

  // Configuration registers
  logic [OFFSET_W-1:0] offset_bits_q;
  logic [INDEX_W-1:0]  index_bits_q;
  logic [WAYS_W-1:0]   ways_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OFFSET_RST;
      index_bits_q  <= INDEX_RST;
      ways_in_use_q <= WAYS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i[OFFSET_W-1:0];
        CFG_INDEX_BITS:  index_bits_q  <= cfg_wdata_i[INDEX_W-1:0];
        CFG_WAYS_IN_USE: ways_in_use_q <= cfg_wdata_i[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings: index width clamped, ways clamped to 1..MAX_WAYS
  logic [INDEX_W-1:0] ib_eff;
  logic [WAYS_W:0]    ways_ext;
  logic [CNT_W-1:0]   ways_eff;

  always_comb begin
    ib_eff   = (index_bits_q > INDEX_MAX) ? INDEX_MAX : index_bits_q;
    ways_ext = {1'b0, ways_in_use_q};
    if (ways_ext == '0) begin
      ways_eff = CNT_W'(1);
    end else if (ways_ext > (WAYS_W + 1)'(MAX_WAYS)) begin
      ways_eff = CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = CNT_W'(ways_ext);
    end
  end

  // Set number to store row (set mod MAX_SETS), constant table
  logic [ROW_W-1:0] row_lut [NSETS];
  for (genvar s = 0; s < NSETS; s++) begin : g_row_lut
    assign row_lut[s] = ROW_W'(s % MAX_SETS);
  end

  // Address split
  logic [ADDR_W-1:0] addr_m;
  logic [SET_W:0]    set_mask;
  logic [SET_W-1:0]  in_set;
  logic [5:0]        tag_sh;
  logic [TAG_W-1:0]  in_tag;
  logic [ROW_W-1:0]  in_row;

  always_comb begin
    addr_m   = req.byte_address & ADDR_MASK;
    set_mask = ((SET_W + 1)'(1) << ib_eff) - (SET_W + 1)'(1);
    in_set   = SET_W'(addr_m >> offset_bits_q) & set_mask[SET_W-1:0];
    tag_sh   = 6'(offset_bits_q) + 6'(ib_eff);
    in_tag   = TAG_W'(addr_m >> tag_sh);
    in_row   = row_lut[in_set];
  end

  // Handshake
  logic out_valid_q;
  logic s1_valid_q;
  logic out_free;
  logic s1_fire;
  logic acc;

  assign out_free  = !out_valid_q || rsp.ready;
  assign s1_fire   = s1_valid_q && out_free;
  assign req.ready = !s1_valid_q || out_free;
  assign acc       = req.valid && req.ready;

  // Row memory and per-row valid flags
  row_t             mem_q [MAX_SETS];
  logic [MAX_SETS-1:0] rowv_q;
  row_t             rd_row_q;
  logic             rd_rowv_q;
  row_t             nxt_row;

  logic [SET_W-1:0] s1_set_q;
  logic [TAG_W-1:0] s1_tag_q;
  logic [ROW_W-1:0] s1_row_q;
  logic             fwd_sel_q;
  row_t             fwd_row_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mem_q[s1_row_q] <= nxt_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_row_q <= mem_q[in_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowv_q <= '0;
    end else if (s1_fire) begin
      rowv_q[s1_row_q] <= 1'b1;
    end
  end

  // Lookup stage registers; forward a row written at the edge it was read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_sel_q  <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_q <= 1'b1;
        fwd_sel_q  <= s1_fire && (in_row == s1_row_q);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_set_q  <= in_set;
      s1_tag_q  <= in_tag;
      s1_row_q  <= in_row;
      rd_rowv_q <= rowv_q[in_row];
    end
    if (s1_fire) begin
      fwd_row_q <= nxt_row;
    end
  end

  // Way compare, fill and FIFO replacement
  row_t             cur;
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             free;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] way_sel;

  always_comb begin
    cur = fwd_sel_q ? fwd_row_q : rd_row_q;
    if (!fwd_sel_q && !rd_rowv_q) begin
      cur.vld = '0;
      cur.ptr = '0;
    end
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit && (CNT_W'(w) < ways_eff) && cur.vld[w] && (cur.tags[w] == s1_tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!free && (CNT_W'(w) < ways_eff) && !cur.vld[w]) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    victim  = (CNT_W'(cur.ptr) < ways_eff) ? cur.ptr : '0;
    nxt_row = cur;
    if (hit) begin
      way_sel = hit_way;
    end else if (free) begin
      way_sel               = free_way;
      nxt_row.tags[way_sel] = s1_tag_q;
      nxt_row.vld[way_sel]  = 1'b1;
    end else begin
      way_sel               = victim;
      nxt_row.tags[way_sel] = s1_tag_q;
      nxt_row.ptr = ((CNT_W'(victim) + CNT_W'(1)) == ways_eff) ? '0
                  : WAY_W'(victim + WAY_W'(1));
    end
  end

  // Result register
  logic             out_hit_q;
  logic [SET_W-1:0] out_set_q;
  logic [TAG_W-1:0] out_tag_q;
  logic [WAY_W-1:0] out_way_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_hit_q <= hit;
      out_set_q <= s1_set_q;
      out_tag_q <= s1_tag_q;
      out_way_q <= way_sel;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.hit        = out_hit_q;
  assign rsp.set_number = out_set_q;
  assign rsp.line_tag   = out_tag_q;
  assign rsp.way_used   = WAY_OUT_W'(out_way_q);

  // Checks
  `SACF_ASSERT(a_fwd_same_row, (acc && s1_fire && (in_row == s1_row_q)) |=> fwd_sel_q,
               "back-to-back access to one row not forwarded")
  `SACF_ASSERT(a_row_marked, s1_fire |=> rowv_q[$past(s1_row_q)],
               "written row not marked valid")
  `SACF_ASSERT(a_result_loaded, s1_fire |=> (out_valid_q && (out_tag_q == $past(s1_tag_q))),
               "lookup result not loaded into result register")
  `SACF_ASSERT_ALWAYS(a_no_rsp_in_reset, !rst_ni |-> !rsp.valid,
                      "result valid during reset")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for set_assoc_cache_fifo_lookup_unit: directed rows, then random traffic
// checked against a behavioral tag/valid/FIFO-pointer model of the cache.
// Depends on sacf_pkg, sacf_if.sv and the lookup unit RTL.

module tb;
  import sacf_pkg::*;

  localparam int unsigned NSETS       = MAX_SETS_DEF;
  localparam int unsigned NWAYS       = MAX_WAYS_DEF;
  localparam int unsigned PIPE_LAT    = 2;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned N_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS = 115;
  localparam int unsigned POOL_N      = 16;

  // One lookup result as seen on the rsp channel
  typedef struct packed {
    logic                 hit;
    logic [SET_W-1:0]     set_no;
    logic [TAG_W-1:0]     line_tag;
    logic [WAY_OUT_W-1:0] way;
  } lookup_t;

  // Directed rows: register write, plain lookup, or lookup with a typed-in result
  typedef enum logic [1:0] {ROW_REG, ROW_LOOK, ROW_CHECK} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [4:0]        val;
    logic [ADDR_W-1:0] addr;
    lookup_t           res;
  } dir_row_t;

  typedef struct {
    bit      fixed;
    lookup_t res;
  } fixed_res_t;

  localparam lookup_t NO_RES = '0;
  localparam int DIR_ROWS = 31;

  // Reset config is offset 3, index 4, one way. Then wide shifts with clamped
  // index/ways, then fully associative fill, FIFO wrap, stale pointer and a
  // duplicated tag resolved to the lowest way.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h0000_0000, {1'b0, 6'd0,  32'h0000_0000, 3'd0}},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h0000_0000, {1'b1, 6'd0,  32'h0000_0000, 3'd0}},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'hFFFF_FFFF, {1'b0, 6'd15, 32'h01FF_FFFF, 3'd0}},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'hFFFF_FFFF, {1'b1, 6'd15, 32'h01FF_FFFF, 3'd0}},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h0000_0080, {1'b0, 6'd0,  32'h0000_0001, 3'd0}},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h0000_0000, {1'b0, 6'd0,  32'h0000_0000, 3'd0}},
    '{ROW_REG,   CFG_WAYS_IN_USE, 5'd0,  32'h0, NO_RES},
    '{ROW_REG,   CFG_INDEX_BITS,  5'd7,  32'h0, NO_RES},
    '{ROW_REG,   CFG_OFFSET_BITS, 5'd31, 32'h0, NO_RES},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h8000_0000, {1'b0, 6'd1,  32'h0000_0000, 3'd0}},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h7FFF_FFFF, {1'b1, 6'd0,  32'h0000_0000, 3'd0}},
    '{ROW_REG,   CFG_OFFSET_BITS, 5'd0,  32'h0, NO_RES},
    '{ROW_REG,   CFG_INDEX_BITS,  5'd0,  32'h0, NO_RES},
    '{ROW_REG,   CFG_WAYS_IN_USE, 5'd9,  32'h0, NO_RES},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h0000_0005, {1'b0, 6'd0,  32'h0000_0005, 3'd1}},
    '{ROW_LOOK,  CFG_OFFSET_BITS, 5'd0,  32'h0000_0006, NO_RES},
    '{ROW_LOOK,  CFG_OFFSET_BITS, 5'd0,  32'h0000_0007, NO_RES},
    '{ROW_LOOK,  CFG_OFFSET_BITS, 5'd0,  32'h0000_0008, NO_RES},
    '{ROW_LOOK,  CFG_OFFSET_BITS, 5'd0,  32'h0000_0009, NO_RES},
    '{ROW_LOOK,  CFG_OFFSET_BITS, 5'd0,  32'h0000_000A, NO_RES},
    '{ROW_LOOK,  CFG_OFFSET_BITS, 5'd0,  32'h0000_000B, NO_RES},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h0000_000C, {1'b0, 6'd0,  32'h0000_000C, 3'd0}},
    '{ROW_LOOK,  CFG_OFFSET_BITS, 5'd0,  32'h0000_0000, NO_RES},
    '{ROW_LOOK,  CFG_OFFSET_BITS, 5'd0,  32'h0000_0005, NO_RES},
    '{ROW_REG,   CFG_WAYS_IN_USE, 5'd2,  32'h0, NO_RES},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h0000_0063, {1'b0, 6'd0,  32'h0000_0063, 3'd0}},
    '{ROW_REG,   CFG_WAYS_IN_USE, 5'd1,  32'h0, NO_RES},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h0000_0007, {1'b0, 6'd0,  32'h0000_0007, 3'd0}},
    '{ROW_REG,   CFG_WAYS_IN_USE, 5'd8,  32'h0, NO_RES},
    '{ROW_CHECK, CFG_OFFSET_BITS, 5'd0,  32'h0000_0007, {1'b1, 6'd0,  32'h0000_0007, 3'd0}},
    '{ROW_LOOK,  CFG_OFFSET_BITS, 5'd0,  32'h0000_0008, NO_RES}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sacf_req_if req_ch ();
  sacf_rsp_if rsp_ch ();

  set_assoc_cache_fifo_lookup_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow registers and cache state of the model
  logic [OFFSET_W-1:0] cur_offset = OFFSET_RST;
  logic [INDEX_W-1:0]  cur_index  = INDEX_RST;
  logic [WAYS_W-1:0]   cur_ways   = WAYS_RST;
  logic [TAG_W-1:0]    line_tags [NSETS][NWAYS];
  bit                  line_valid [NSETS][NWAYS];
  int unsigned         fifo_ptr [NSETS];

  lookup_t     expected_lookups [$];
  fixed_res_t  fixed_res_q [$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_fail = 0;
  int unsigned n_checked = 0;
  int unsigned n_hits = 0;
  int unsigned n_writes = 0;
  logic [ADDR_W-1:0] addr_pool [POOL_N];

  // Look up one address, fill or replace on a miss, return the result
  function automatic lookup_t lookup_and_fill(input logic [ADDR_W-1:0] addr);
    int unsigned ib, nways, row, w, sh;
    logic [31:0] set_v;
    logic [TAG_W-1:0] tag_v;
    bit found;
    lookup_t r;
    ib    = (cur_index > INDEX_MAX) ? INDEX_MAX : cur_index;
    nways = (cur_ways == 0) ? 1 : ((cur_ways > NWAYS) ? NWAYS : cur_ways);
    set_v = (addr >> cur_offset) & ((32'd1 << ib) - 32'd1);
    sh    = cur_offset + ib;
    tag_v = (sh >= ADDR_W) ? '0 : addr >> sh;
    row   = set_v % NSETS;
    r = '0;
    r.set_no   = set_v[SET_W-1:0];
    r.line_tag = tag_v;
    found = 1'b0;
    // lowest matching valid way wins
    for (w = 0; w < nways && !found; w++) begin
      if (line_valid[row][w] && line_tags[row][w] == tag_v) begin
        found = 1'b1;
        r.hit = 1'b1;
        r.way = 3'(w);
      end
    end
    if (!found) begin
      for (w = 0; w < nways && !found; w++) begin
        if (!line_valid[row][w]) begin
          found = 1'b1;
          r.way = 3'(w);
        end
      end
      if (found) begin
        line_tags[row][r.way]  = tag_v;
        line_valid[row][r.way] = 1'b1;
      end else begin
        // set full: FIFO victim, a stale pointer falls back to way 0
        w = (fifo_ptr[row] < nways) ? fifo_ptr[row] : 0;
        r.way = 3'(w);
        line_tags[row][w] = tag_v;
        fifo_ptr[row] = (w + 1) % nways;
      end
    end
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Receiver stalls, accept-side prediction and result checking
  always @(posedge clk_i) begin : scoreboard
    lookup_t    pred;
    lookup_t    got;
    lookup_t    want;
    fixed_res_t fr;
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        pred = lookup_and_fill(req_ch.byte_address);
        fr = fixed_res_q.pop_front();
        expected_lookups.push_back(fr.fixed ? fr.res : pred);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.hit      = rsp_ch.hit;
        got.set_no   = rsp_ch.set_number;
        got.line_tag = rsp_ch.line_tag;
        got.way      = rsp_ch.way_used;
        if (expected_lookups.size() == 0) begin
          note_failure($sformatf("result with nothing pending: hit %0b set %0d tag %h way %0d",
                                 got.hit, got.set_no, got.line_tag, got.way));
        end else begin
          want = expected_lookups.pop_front();
          n_checked++;
          if (got.hit) n_hits++;
          if (got.hit !== want.hit || got.set_no !== want.set_no ||
              got.line_tag !== want.line_tag || got.way !== want.way) begin
            note_failure($sformatf("exp hit %0b set %0d tag %h way %0d, got hit %0b set %0d tag %h way %0d",
                                   want.hit, want.set_no, want.line_tag, want.way,
                                   got.hit, got.set_no, got.line_tag, got.way));
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_lookups.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Register write; the enable stays high so back-to-back writes need no toggle
  task automatic reg_write(input cfg_idx_e idx, input logic [4:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_OFFSET_BITS: cur_offset = val;
      CFG_INDEX_BITS:  cur_index  = val[INDEX_W-1:0];
      CFG_WAYS_IN_USE: cur_ways   = val[WAYS_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // One lookup transaction, with random idle cycles ahead of it
  task automatic push_addr(input logic [ADDR_W-1:0] a, input bit fixed, input lookup_t res);
    fixed_res_q.push_back('{fixed, res});
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.byte_address <= a;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Stop sending and wait until every sent transaction has its result back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (fixed_res_q.size() != 0 || expected_lookups.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  initial begin
    logic [4:0]        off_v, idx_v, ways_v;
    logic [ADDR_W-1:0] a, lo_mask, set_mask;
    int unsigned       ib;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_OFFSET_BITS;
    cfg_wdata_i         = '0;
    req_ch.valid        = 1'b0;
    req_ch.byte_address = '0;
    rsp_ch.ready        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_REG) drain();
        reg_write(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        cfg_we_i <= 1'b0;
        push_addr(dir_rows[i].addr, dir_rows[i].kind == ROW_CHECK, dir_rows[i].res);
      end
    end

    // Random phases: new register setting and idle pattern each phase
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: begin off_v = 5'd3;  idx_v = 5'd4; ways_v = 5'd4;  end
        1: begin off_v = 5'd0;  idx_v = 5'd0; ways_v = 5'd8;  end
        2: begin off_v = 5'd31; idx_v = 5'd7; ways_v = 5'd0;  end
        3: begin off_v = 5'd16; idx_v = 5'd6; ways_v = 5'd15; end
        4: begin off_v = 5'd4;  idx_v = 5'd1; ways_v = 5'd2;  end
        default: begin
          off_v  = 5'($urandom_range(20));
          idx_v  = 5'($urandom_range(7));
          ways_v = 5'($urandom_range(15));
        end
      endcase
      reg_write(CFG_OFFSET_BITS, off_v);
      reg_write(CFG_INDEX_BITS, idx_v);
      reg_write(CFG_WAYS_IN_USE, ways_v);
      cfg_we_i <= 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase

      // Small pool of lines, half of them crowded into sets 0..2, so sets fill and evict
      ib       = (cur_index > INDEX_MAX) ? INDEX_MAX : cur_index;
      set_mask = ((32'd1 << ib) - 32'd1) << cur_offset;
      lo_mask  = (32'd1 << cur_offset) - 32'd1;
      for (int k = 0; k < POOL_N; k++) begin
        a = $urandom();
        if (k % 2 == 1) a = (a & ~set_mask) | ((32'(k % 3) << cur_offset) & set_mask);
        addr_pool[k] = a;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly reuse of pool lines with random byte offsets, some fresh addresses
        if ($urandom_range(99) < 80)
          a = (addr_pool[$urandom_range(POOL_N-1)] & ~lo_mask) | ($urandom() & lo_mask);
        else
          a = $urandom();
        push_addr(a, 1'b0, NO_RES);
        // in phase 2 the sender holds off once mid-phase until the pipe is empty
        if (p == 2 && n == 60) drain();
      end
    end

    drain();
    $display("Checked %0d lookups, %0d hits, over %0d register writes",
             n_checked, n_hits, n_writes);
    $display("Traffic ran with no gaps, sparse sender, stalling receiver and mixed gaps");
    if (n_fail == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
